FILE: rtl/crt_two_moduli_combine_assert.svh
// ----------------------------------------------------------------------------
// crt assertion macros
// shared property shorthands for the crt checker
// ----------------------------------------------------------------------------
`ifndef CRT_TWO_MODULI_COMBINE_ASSERT_SVH
`define CRT_TWO_MODULI_COMBINE_ASSERT_SVH

// implication checked on every edge outside reset
`define CRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crt check failed");

// next-cycle implication checked outside reset
`define CRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crt check failed");

`endif

FILE: rtl/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt package
// sequencer states and operation codes for the crt combiner
// ----------------------------------------------------------------------------
package crt_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RA,      // r1 mod p1
    ST_RB1,     // r1 mod p2
    ST_RB2,     // r2 mod p2
    ST_BASE,    // p1 mod p2
    ST_EXP,     // exponent loop decision
    ST_MULA,    // acc = acc*base mod p2
    ST_SQR,     // base = base*base mod p2
    ST_KMUL,    // k = diff*inv mod p2
    ST_SOL,     // product k*p1
    ST_OUT
  } crt_state_t;

  // multiply-reduce unit request
  typedef struct packed {
    logic        start;
    logic        reduce;   // 1: a*b mod m, 0: plain a*b
  } crt_mr_ctl_t;

endpackage

FILE: rtl/crt_two_moduli_combine.sv
// ----------------------------------------------------------------------------
// crt two moduli combiner
// solves x mod p1 = r1, x mod p2 = r2 with a fermat inverse mod prime p2
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | tdata: residue_a, residue_b
// out_    | out | tdata: solution (62 bits, padded to 64)
// cfg_    | in  | index 0 modulus_a, index 1 modulus_b
//
// one item takes 4 + bits(p2-2) + ones(p2-2) + 1 reduce passes of the shared
// multiply-reduce unit, one plain multiply and one exponent loop decision per
// exponent bit; a single pass when p2 is below 2
// the single multiply-reduce unit sets the rate; one item in flight at a time
// rst_n is synchronous; moduli reset to 2 and 3
// the result holds in the output register until out_tready; in_tready is low
// from acceptance until the result beat is taken, cfg_ready likewise
module crt_two_moduli_combine #(
  parameter int MOD_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [8*((2*MOD_WIDTH+7)/8)-1:0] in_tdata, // residue_a, residue_b
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [63:0]            out_tdata,          // solution
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [MOD_WIDTH-1:0]   cfg_data
);
  import crt_pkg::*;

  localparam int W = MOD_WIDTH;

  logic [W-1:0]   p1_r, p2_r;
  logic           busy;
  crt_mr_ctl_t    ctl;
  logic [W-1:0]   op_a, op_b, op_m;
  logic           mr_done;
  logic [2*W-1:0] mr_res;
  logic [61:0]    sol;

  // configuration registers, written only while idle
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= W'(2);
      p2_r <= W'(3);
    end else if (cfg_valid && cfg_ready) begin
      if (!cfg_index) p1_r <= cfg_data;
      else            p2_r <= cfg_data;
    end
  end

  assign in_tready = !busy;

  crt_seq #(.W(W)) u_seq (
    .clk, .rst_n,
    .start    (in_tvalid && !busy),
    .p1       (p1_r),
    .p2       (p2_r),
    .r1_in    (in_tdata[W-1:0]),
    .r2_in    (in_tdata[2*W-1:W]),
    .out_take (out_tready),
    .busy,
    .out_valid(out_tvalid),
    .out_sol  (sol),
    .ctl, .op_a, .op_b, .op_m,
    .mr_done, .mr_res
  );

  crt_mulmod #(.W(W)) u_mr (
    .clk, .rst_n, .ctl,
    .a(op_a), .b(op_b), .m(op_m),
    .done(mr_done), .res(mr_res)
  );

  assign out_tdata = {2'b00, sol};
endmodule

FILE: rtl/crt_mulmod.sv
// ----------------------------------------------------------------------------
// crt multiply-reduce unit
// shift-add multiply with bit-serial restoring reduction, one bit per cycle
// ----------------------------------------------------------------------------
module crt_mulmod #(
  parameter int W = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crt_pkg::crt_mr_ctl_t ctl,
  input  logic [W-1:0]         a,
  input  logic [W-1:0]         b,
  input  logic [W-1:0]         m,
  output logic                 done,
  output logic [2*W-1:0]       res
);
  import crt_pkg::*;

  localparam int CW = $clog2(2*W+1);

  // phase 0: multiply, phase 1: reduce
  logic              busy_r, busy_nxt;
  logic              phase_r, phase_nxt;
  logic              red_r, red_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [2*W-1:0]    prod_r, prod_nxt;
  logic [W-1:0]      mb_r, mb_nxt;
  logic [2*W-1:0]    ma_r, ma_nxt;
  logic [W:0]        rem_r, rem_nxt;
  logic [W-1:0]      mod_r, mod_nxt;
  logic              done_r, done_nxt;
  logic [W+1:0]      trial;
  logic [W:0]        sh;

  assign sh    = {rem_r[W-1:0], prod_r[2*W-1]};
  assign trial = {1'b0, sh} - {2'b00, mod_r};

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    red_nxt   = red_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    mb_nxt    = mb_r;
    ma_nxt    = ma_r;
    rem_nxt   = rem_r;
    mod_nxt   = mod_r;
    done_nxt  = 1'b0;
    if (ctl.start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      red_nxt   = ctl.reduce;
      cnt_nxt   = CW'(W);
      prod_nxt  = '0;
      ma_nxt    = {{W{1'b0}}, a};
      mb_nxt    = b;
      mod_nxt   = m;
    end else if (busy_r) begin
      if (!phase_r) begin
        if (mb_r[0]) prod_nxt = prod_r + ma_r;
        ma_nxt  = {ma_r[2*W-2:0], 1'b0};
        mb_nxt  = mb_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          if (red_r) begin
            phase_nxt = 1'b1;
            cnt_nxt   = CW'(2*W);
            rem_nxt   = '0;
          end else begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
      end else begin
        // remainder stays below m, so one compare-subtract per bit
        if (!trial[W+1]) rem_nxt = trial[W:0];
        else             rem_nxt = sh;
        prod_nxt = {prod_r[2*W-2:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          prod_nxt = {{(W-1){1'b0}}, rem_nxt};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    phase_r <= phase_nxt;
    red_r   <= red_nxt;
    cnt_r   <= cnt_nxt;
    prod_r  <= prod_nxt;
    mb_r    <= mb_nxt;
    ma_r    <= ma_nxt;
    rem_r   <= rem_nxt;
    mod_r   <= mod_nxt;
  end

  assign done = done_r;
  assign res  = prod_r;
endmodule

FILE: rtl/crt_seq.sv
// ----------------------------------------------------------------------------
// crt sequencer
// walks reductions, fermat exponentiation and the final product
// ----------------------------------------------------------------------------
module crt_seq #(
  parameter int W = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [W-1:0]         p1,
  input  logic [W-1:0]         p2,
  input  logic [W-1:0]         r1_in,
  input  logic [W-1:0]         r2_in,
  input  logic                 out_take,
  output logic                 busy,
  output logic                 out_valid,
  output logic [61:0]          out_sol,
  output crt_pkg::crt_mr_ctl_t ctl,
  output logic [W-1:0]         op_a,
  output logic [W-1:0]         op_b,
  output logic [W-1:0]         op_m,
  input  logic                 mr_done,
  input  logic [2*W-1:0]       mr_res
);
  import crt_pkg::*;

  localparam int SW = (2*W > 62) ? 2*W + 1 : 63;

  crt_state_t     st_r, st_nxt;
  logic           wait_r, wait_nxt;
  logic [W-1:0]   r1_r, r1_nxt, r2_r, r2_nxt;
  logic [W-1:0]   diff_r, diff_nxt, base_r, base_nxt, acc_r, acc_nxt, exp_r, exp_nxt;
  logic [61:0]    sol_r, sol_nxt;
  logic [W-1:0]   rb1_r, rb1_nxt;
  logic [W:0]     dsum;
  logic [SW-1:0]  wsum;
  logic           p2ok;

  assign p2ok = (p2 > W'(1));
  assign dsum = {1'b0, r2_r} + {1'b0, p2} - {1'b0, rb1_r};
  assign wsum = SW'(mr_res) + SW'(r1_r);

  always_comb begin
    st_nxt = st_r;
    if (wait_r) begin
      if (mr_done) begin
        unique case (st_r)
          ST_RA:   st_nxt = p2ok ? ST_RB1 : ST_OUT;
          ST_RB1:  st_nxt = ST_RB2;
          ST_RB2:  st_nxt = ST_BASE;
          ST_BASE: st_nxt = ST_EXP;
          ST_MULA: st_nxt = ST_SQR;
          ST_SQR:  st_nxt = ST_EXP;
          ST_KMUL: st_nxt = ST_SOL;
          ST_SOL:  st_nxt = ST_OUT;
          default: st_nxt = st_r;
        endcase
      end
    end else begin
      unique case (st_r)
        ST_IDLE: if (start) st_nxt = ST_RA;
        ST_EXP:  begin
          if (exp_r == '0)  st_nxt = ST_KMUL;
          else if (exp_r[0]) st_nxt = ST_MULA;
          else               st_nxt = ST_SQR;
        end
        ST_OUT:  if (out_take) st_nxt = ST_IDLE;
        default: st_nxt = st_r;
      endcase
    end
  end

  always_comb begin
    wait_nxt = wait_r;
    ctl      = '0;
    op_a     = '0;
    op_b     = W'(1);
    op_m     = p2;
    r1_nxt = r1_r; r2_nxt = r2_r; diff_nxt = diff_r; base_nxt = base_r;
    acc_nxt = acc_r; exp_nxt = exp_r; sol_nxt = sol_r; rb1_nxt = rb1_r;
    if (wait_r) begin
      if (mr_done) begin
        wait_nxt = 1'b0;
        unique case (st_r)
          ST_RA:   begin
            r1_nxt  = mr_res[W-1:0];
            sol_nxt = 62'(mr_res[W-1:0]);
          end
          ST_RB1:  rb1_nxt  = mr_res[W-1:0];
          ST_RB2:  r2_nxt   = mr_res[W-1:0];
          ST_BASE: base_nxt = mr_res[W-1:0];
          ST_MULA: acc_nxt  = mr_res[W-1:0];
          ST_SQR:  begin
            base_nxt = mr_res[W-1:0];
            exp_nxt  = exp_r >> 1;
          end
          ST_KMUL: diff_nxt = mr_res[W-1:0];
          ST_SOL:  sol_nxt  = wsum[61:0];
          default: ;
        endcase
      end
    end else begin
      unique case (st_r)
        ST_IDLE: if (start) begin
          r1_nxt = r1_in;
          r2_nxt = r2_in;
        end
        ST_EXP: if (exp_r == '0) begin
          ctl      = '{start: 1'b1, reduce: 1'b1};
          op_a     = diff_r;
          op_b     = acc_r;
          wait_nxt = 1'b1;
        end else if (exp_r[0]) begin
          ctl      = '{start: 1'b1, reduce: 1'b1};
          op_a     = acc_r;
          op_b     = base_r;
          wait_nxt = 1'b1;
        end else begin
          ctl      = '{start: 1'b1, reduce: 1'b1};
          op_a     = base_r;
          op_b     = base_r;
          wait_nxt = 1'b1;
        end
        default: ;
      endcase
      // launch steps entering a state that needs the unit
      if (st_r == ST_IDLE && start) begin
        // r1 mod p1, or plain r1*1 when p1 is zero
        ctl      = '{start: 1'b1, reduce: (p1 != '0)};
        op_a     = r1_in;
        op_m     = p1;
        wait_nxt = 1'b1;
      end
    end
    // chained launches, or the exponent loop setup, right after a completion
    if (wait_r && mr_done) begin
      unique case (st_r)
        ST_RA: if (p2ok) begin
          ctl = '{start: 1'b1, reduce: 1'b1}; op_a = mr_res[W-1:0]; wait_nxt = 1'b1;
        end
        ST_RB1: begin
          ctl = '{start: 1'b1, reduce: 1'b1}; op_a = r2_r; wait_nxt = 1'b1;
        end
        ST_RB2: begin
          ctl = '{start: 1'b1, reduce: 1'b1}; op_a = p1; wait_nxt = 1'b1;
        end
        ST_BASE: begin
          acc_nxt  = W'(1);
          exp_nxt  = p2 - W'(2);
          // diff = (r2b + p2 - r1b) mod p2
          diff_nxt = (dsum >= {1'b0, p2}) ? W'(dsum - {1'b0, p2}) : dsum[W-1:0];
        end
        ST_MULA: begin
          ctl = '{start: 1'b1, reduce: 1'b1}; op_a = base_r; op_b = base_r;
          wait_nxt = 1'b1;
        end
        ST_KMUL: begin
          ctl = '{start: 1'b1, reduce: 1'b0}; op_a = mr_res[W-1:0]; op_b = p1;
          wait_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      wait_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      wait_r <= wait_nxt;
    end
    r1_r <= r1_nxt; r2_r <= r2_nxt; diff_r <= diff_nxt; base_r <= base_nxt;
    acc_r <= acc_nxt; exp_r <= exp_nxt; sol_r <= sol_nxt; rb1_r <= rb1_nxt;
  end

  assign busy      = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign out_sol   = sol_r;
endmodule

FILE: rtl/crt_chk.sv
// ----------------------------------------------------------------------------
// crt port checker
// watches handshakes on the top level ports
// ----------------------------------------------------------------------------
`include "crt_two_moduli_combine_assert.svh"
module crt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);
  `CRT_ASSERT_IMP(a_excl, out_tvalid, !in_tready)
  `CRT_ASSERT_NXT(a_busy, in_tvalid && in_tready, !in_tready)
  `CRT_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `CRT_ASSERT_IMP(a_pad, out_tvalid, out_tdata[63:62] == 2'b00)
endmodule

bind crt_two_moduli_combine crt_chk u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

FILE: bench/tb_crt_two_moduli_combine.sv
// ----------------------------------------------------------------------------
// crt combiner testbench
// drives residue pairs under several modulus settings, predicts each combined
// value with a local fermat-inverse model and checks every result beat in order
// ----------------------------------------------------------------------------
class crt_scoreboard;
  logic [61:0] pending_solutions[$];
  int          mismatches;
  logic [30:0] mod_a;
  logic [30:0] mod_b;

  function new();
    mismatches = 0;
    mod_a = 31'd2;
    mod_b = 31'd3;
  endfunction

  // base^ex mod m, products stay within 62 bits
  function logic [63:0] pow_mod(logic [63:0] base, logic [63:0] ex, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    while (ex != 0) begin
      if (ex[0]) acc = (acc * base) % m;
      base = (base * base) % m;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function logic [61:0] combine(logic [30:0] ra, logic [30:0] rb);
    logic [63:0] p1, p2, r1, r2, k, diff, inv;
    p1 = mod_a;
    p2 = mod_b;
    r1 = ra;
    r2 = rb;
    k = 0;
    if (p1 != 0) r1 = r1 % p1;
    if (p2 >= 2) begin
      diff = ((r2 % p2) + p2 - (r1 % p2)) % p2;
      inv = pow_mod(p1 % p2, p2 - 2, p2);
      k = (diff * inv) % p2;
    end
    return 62'(r1 + k * p1);
  endfunction

  function void note_input(logic [30:0] ra, logic [30:0] rb);
    pending_solutions = {pending_solutions, combine(ra, rb)};
  endfunction

  function void check_result(logic [63:0] got);
    logic [61:0] want;
    if (pending_solutions.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %0d", got);
      return;
    end
    want = pending_solutions.pop_front();
    if (got[61:0] !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("solution mismatch: expected %0d got %0d", want, got[61:0]);
    end
  endfunction
endclass

module tb_crt_two_moduli_combine;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [30:0] cfg_data = '0;

  crt_scoreboard sb = new();
  bit quiet_sender;   // no idle gaps on the input side
  bit quiet_receiver; // no stalls on the result side
  int hold_cycles;    // long receiver hold-off, counted below

  always #5 clk = ~clk;

  crt_two_moduli_combine #(.MOD_WIDTH(31)) uut (.*);

  // receiver: random stalls, plus a long counted hold-off on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet_receiver ? 1'b1 : ($urandom_range(99) >= 17);
      end
    end
  end

  // register write while idle
  task automatic write_reg(bit idx, logic [30:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx) sb.mod_b = val;
    else sb.mod_a = val;
  endtask

  // one residue pair beat, with an optional random gap ahead of it
  task automatic send_pair(logic [30:0] ra, logic [30:0] rb);
    if (!quiet_sender && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 17);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, rb, ra};
    do @(posedge clk); while (!in_tready);
    sb.note_input(ra, rb);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_solutions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // residue below the modulus or below twice the modulus, sometimes anything
  function automatic logic [30:0] pick_residue(logic [30:0] m);
    if (m == 0 || $urandom_range(3) == 0) return 31'($urandom());
    return 31'($urandom() % (32'(m) * ($urandom_range(1) + 1)));
  endfunction

  // prime second moduli, small ones for speed and the extremes
  logic [30:0] primes[8] = '{31'd3, 31'd5, 31'd7, 31'd13, 31'd101, 31'd65521,
                            31'd2147483629, 31'd2147483647};

  initial begin
    logic [30:0] ma;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;

    // directed: reset moduli, then field extremes
    send_pair(31'd1, 31'd2);
    send_pair(31'h7fffffff, 31'h7fffffff);
    send_pair(31'd0, 31'd0);
    drain();
    // largest moduli
    write_reg(1'b0, 31'h7fffffff);
    write_reg(1'b1, 31'd2147483629);
    send_pair(31'h7ffffffe, 31'd2147483628);
    send_pair(31'h7fffffff, 31'h7fffffff);
    send_pair(31'h55555555, 31'h2aaaaaaa);
    drain();
    // modulus_b of two gives an inverse of one
    write_reg(1'b1, 31'd2);
    send_pair(31'd5, 31'd1);
    drain();
    // modulus_a zero keeps residue_a unreduced
    write_reg(1'b0, 31'd0);
    write_reg(1'b1, 31'd7);
    send_pair(31'h7fffffff, 31'd3);
    drain();
    // modulus_b zero and one
    write_reg(1'b0, 31'd10);
    write_reg(1'b1, 31'd0);
    send_pair(31'd23, 31'd4);
    drain();
    write_reg(1'b1, 31'd1);
    send_pair(31'd23, 31'd4);
    drain();
    // non-prime modulus_b and modulus_a a multiple of modulus_b
    write_reg(1'b1, 31'd9);
    send_pair(31'd4, 31'd8);
    drain();
    write_reg(1'b0, 31'd14);
    write_reg(1'b1, 31'd7);
    send_pair(31'd3, 31'd5);
    drain();

    // pressure: receiver holds off while the sender keeps offering beats
    write_reg(1'b0, 31'd12);
    write_reg(1'b1, 31'd13);
    hold_cycles = 4000;
    repeat (4) send_pair(31'($urandom()), 31'($urandom()));
    drain();

    // random phases across several settings
    for (int ph = 0; ph < 8; ph++) begin
      ma = (ph == 0) ? 31'd2 : (ph == 1) ? 31'h7fffffff : 31'($urandom_range(100, 2));
      if (ph > 4) ma = 31'($urandom());
      write_reg(1'b0, ma);
      write_reg(1'b1, (ph < 2) ? primes[7 - ph] : primes[$urandom_range(5)]);
      quiet_sender = (ph == 3);
      quiet_receiver = (ph == 3);
      repeat (16) send_pair(pick_residue(sb.mod_a), pick_residue(sb.mod_b));
      // sender waits until every result is back
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_solutions.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #60000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
